### src/ptt_pkg.sv
// Shared types, constants and product schedule for the point-in-triangle test.
package ptt_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int DIGIT_BITS      = 8;
	localparam int NUM_VERTS       = 3;
	localparam int NUM_PRODS       = 21;
	localparam int PIDX_W          = $clog2(NUM_PRODS);
	localparam logic [PIDX_W-1:0] LAST_PROD = PIDX_W'(NUM_PRODS - 1);
	localparam logic [1:0] SLOT_NONE = 2'd3;
	localparam logic KIND_LOAD = 1'b0;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_WZERO = 2'd1,
		OP_TEST  = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		SRC_V0X = 4'd0,
		SRC_V0Y = 4'd1,
		SRC_V0Z = 4'd2,
		SRC_V1X = 4'd3,
		SRC_V1Y = 4'd4,
		SRC_V1Z = 4'd5,
		SRC_V2X = 4'd6,
		SRC_V2Y = 4'd7,
		SRC_V2Z = 4'd8,
		SRC_D00 = 4'd9,
		SRC_D01 = 4'd10,
		SRC_D02 = 4'd11,
		SRC_D11 = 4'd12,
		SRC_D12 = 4'd13
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE = 4'd0,
		DST_D00  = 4'd1,
		DST_D01  = 4'd2,
		DST_D02  = 4'd3,
		DST_D11  = 4'd4,
		DST_D12  = 4'd5,
		DST_DEN  = 4'd6,
		DST_NU   = 4'd7,
		DST_NV   = 4'd8
	} dst_t;

	typedef struct packed {
		src_t a;
		src_t b;
		logic neg;
		dst_t dst;
	} prod_step_t;

	// Product schedule: five dot products of three terms, then den, nu, nv.
	function automatic prod_step_t prod_step(input logic [PIDX_W-1:0] idx);
		prod_step_t r;
		unique case (idx)
			5'd0:  r = '{SRC_V0X, SRC_V0X, 1'b0, DST_NONE};
			5'd1:  r = '{SRC_V0Y, SRC_V0Y, 1'b0, DST_NONE};
			5'd2:  r = '{SRC_V0Z, SRC_V0Z, 1'b0, DST_D00};
			5'd3:  r = '{SRC_V0X, SRC_V1X, 1'b0, DST_NONE};
			5'd4:  r = '{SRC_V0Y, SRC_V1Y, 1'b0, DST_NONE};
			5'd5:  r = '{SRC_V0Z, SRC_V1Z, 1'b0, DST_D01};
			5'd6:  r = '{SRC_V0X, SRC_V2X, 1'b0, DST_NONE};
			5'd7:  r = '{SRC_V0Y, SRC_V2Y, 1'b0, DST_NONE};
			5'd8:  r = '{SRC_V0Z, SRC_V2Z, 1'b0, DST_D02};
			5'd9:  r = '{SRC_V1X, SRC_V1X, 1'b0, DST_NONE};
			5'd10: r = '{SRC_V1Y, SRC_V1Y, 1'b0, DST_NONE};
			5'd11: r = '{SRC_V1Z, SRC_V1Z, 1'b0, DST_D11};
			5'd12: r = '{SRC_V1X, SRC_V2X, 1'b0, DST_NONE};
			5'd13: r = '{SRC_V1Y, SRC_V2Y, 1'b0, DST_NONE};
			5'd14: r = '{SRC_V1Z, SRC_V2Z, 1'b0, DST_D12};
			5'd15: r = '{SRC_D00, SRC_D11, 1'b0, DST_NONE};
			5'd16: r = '{SRC_D01, SRC_D01, 1'b1, DST_DEN};
			5'd17: r = '{SRC_D11, SRC_D02, 1'b0, DST_NONE};
			5'd18: r = '{SRC_D01, SRC_D12, 1'b1, DST_NU};
			5'd19: r = '{SRC_D00, SRC_D12, 1'b0, DST_NONE};
			5'd20: r = '{SRC_D01, SRC_D02, 1'b1, DST_NV};
			default: r = '{SRC_V0X, SRC_V0X, 1'b0, DST_NONE};
		endcase
		return r;
	endfunction

endpackage

### src/ptt_if.sv
// Valid/ready channel interfaces for test items and results.
interface ptt_in_if
	import ptt_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [1:0]                    vertex_slot;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;
	logic signed [COORD_WIDTH-1:0] coord_w;

	modport source (output valid, kind, vertex_slot, coord_x, coord_y, coord_z, coord_w,
		input ready);
	modport sink (input valid, kind, vertex_slot, coord_x, coord_y, coord_z, coord_w,
		output ready);
endinterface

interface ptt_out_if;
	logic valid;
	logic ready;
	logic is_inside;
	logic degenerate;
	logic w_is_zero;

	modport source (output valid, is_inside, degenerate, w_is_zero, input ready);
	modport sink (input valid, is_inside, degenerate, w_is_zero, output ready);
endinterface

### src/ptt_front.sv
// Front end: accepts transactions, classifies them and queues them for the back end.
module ptt_front
	import ptt_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ptt_in_if.sink                        items,
	output logic                          q_valid,
	input  logic                          q_pop,
	output op_t                           q_op,
	output logic [1:0]                    q_slot,
	output logic signed [COORD_WIDTH-1:0] q_x,
	output logic signed [COORD_WIDTH-1:0] q_y,
	output logic signed [COORD_WIDTH-1:0] q_z,
	output logic signed [COORD_WIDTH-1:0] q_w
);

	localparam int QDEPTH = 2;

	op_t                           op_q [QDEPTH];
	logic [1:0]                    slot_q [QDEPTH];
	logic signed [COORD_WIDTH-1:0] x_q [QDEPTH];
	logic signed [COORD_WIDTH-1:0] y_q [QDEPTH];
	logic signed [COORD_WIDTH-1:0] z_q [QDEPTH];
	logic signed [COORD_WIDTH-1:0] w_q [QDEPTH];
	logic                          wr_ptr_q;
	logic                          rd_ptr_q;
	logic [1:0]                    cnt_q;

	logic accept;
	logic push;
	logic pop;
	op_t  op_in;

	assign items.ready = (cnt_q != 2'(QDEPTH));
	assign accept      = items.valid && items.ready;

	// A load to the unused slot changes nothing and is dropped here.
	assign push = accept && !(items.kind == KIND_LOAD && items.vertex_slot == SLOT_NONE);
	assign pop  = q_pop && q_valid;

	always_comb begin
		if (items.kind == KIND_LOAD) begin
			op_in = OP_LOAD;
		end else if (items.coord_w == '0) begin
			op_in = OP_WZERO;
		end else begin
			op_in = OP_TEST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]   <= op_in;
			slot_q[wr_ptr_q] <= items.vertex_slot;
			x_q[wr_ptr_q]    <= items.coord_x;
			y_q[wr_ptr_q]    <= items.coord_y;
			z_q[wr_ptr_q]    <= items.coord_z;
			w_q[wr_ptr_q]    <= items.coord_w;
		end
	end

	assign q_valid = (cnt_q != '0);
	assign q_op    = op_q[rd_ptr_q];
	assign q_slot  = slot_q[rd_ptr_q];
	assign q_x     = x_q[rd_ptr_q];
	assign q_y     = y_q[rd_ptr_q];
	assign q_z     = z_q[rd_ptr_q];
	assign q_w     = w_q[rd_ptr_q];

endmodule

### src/ptt_div.sv
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / dvs, saturated.
module ptt_div
	import ptt_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_WIDTH-1:0] num,
	input  logic signed [COORD_WIDTH-1:0] dvs,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] quo
);

	localparam int N     = COORD_WIDTH + FRAC_BITS;
	localparam int CNT_W = $clog2(N + 1);
	localparam logic [N-1:0] QMAX     = {{(FRAC_BITS + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic [N-1:0] QMIN_MAG = {{FRAC_BITS{1'b0}}, 1'b1, {(COORD_WIDTH - 1){1'b0}}};

	logic [N-1:0]           dvd_q;
	logic [N-1:0]           quo_q;
	logic [COORD_WIDTH-1:0] rem_q;
	logic [COORD_WIDTH-1:0] dsr_q;
	logic                   neg_q;
	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;

	logic [COORD_WIDTH-1:0] num_mag;
	logic [COORD_WIDTH-1:0] dvs_mag;
	logic [COORD_WIDTH:0]   rem_sh;
	logic [COORD_WIDTH+1:0] trial;
	logic                   qbit;
	logic [COORD_WIDTH-1:0] rem_next;
	logic [COORD_WIDTH-1:0] quo_lo;

	assign num_mag  = num[COORD_WIDTH-1] ? ($unsigned(~num) + 1'b1) : $unsigned(num);
	assign dvs_mag  = dvs[COORD_WIDTH-1] ? ($unsigned(~dvs) + 1'b1) : $unsigned(dvs);
	assign rem_sh   = {rem_q, dvd_q[N-1]};
	assign trial    = {1'b0, rem_sh} - {2'b00, dsr_q};
	assign qbit     = !trial[COORD_WIDTH+1];
	assign rem_next = qbit ? trial[COORD_WIDTH-1:0] : rem_sh[COORD_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
			quo_q <= '0;
			rem_q <= '0;
			dsr_q <= dvs_mag;
			neg_q <= num[COORD_WIDTH-1] ^ dvs[COORD_WIDTH-1];
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[N-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	// Magnitude is floored, so applying the sign truncates toward zero.
	assign quo_lo = quo_q[COORD_WIDTH-1:0];
	always_comb begin
		if (neg_q) begin
			quo = (quo_q > QMIN_MAG) ? $signed(QMIN_MAG[COORD_WIDTH-1:0])
				: $signed(~quo_lo + 1'b1);
		end else begin
			quo = (quo_q > QMAX) ? $signed(QMAX[COORD_WIDTH-1:0]) : $signed(quo_lo);
		end
	end

	assign done = done_q;

endmodule

### src/ptt_mul.sv
// Shared signed multiplier, one digit of b per cycle, most significant digit first.
module ptt_mul
	import ptt_pkg::*;
#(
	parameter int MW = 2 * COORD_WIDTH_DEF + 3 - FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [MW-1:0]   a,
	input  logic signed [MW-1:0]   b,
	output logic                   done,
	output logic signed [2*MW-1:0] prod
);

	localparam int ND    = (MW + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int BP    = ND * DIGIT_BITS;
	localparam int RW    = MW + BP;
	localparam int CNT_W = $clog2(ND + 1);

	logic [MW-1:0]    amag_q;
	logic [BP-1:0]    bmag_q;
	logic [RW-1:0]    acc_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	logic [MW-1:0]            a_mag;
	logic [MW-1:0]            b_mag;
	logic [DIGIT_BITS-1:0]    digit;
	logic [MW+DIGIT_BITS-1:0] pp;
	logic [2*MW-1:0]          mag;

	assign a_mag = a[MW-1] ? ($unsigned(~a) + 1'b1) : $unsigned(a);
	assign b_mag = b[MW-1] ? ($unsigned(~b) + 1'b1) : $unsigned(b);
	assign digit = bmag_q[BP-1 -: DIGIT_BITS];
	assign pp    = amag_q * digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ND);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			amag_q <= a_mag;
			bmag_q <= BP'(b_mag);
			acc_q  <= '0;
			neg_q  <= a[MW-1] ^ b[MW-1];
		end else if (busy_q) begin
			acc_q  <= (acc_q << DIGIT_BITS) + RW'(pp);
			bmag_q <= bmag_q << DIGIT_BITS;
		end
	end

	assign mag  = acc_q[2*MW-1:0];
	assign prod = neg_q ? $signed(~mag + 1'b1) : $signed(mag);
	assign done = done_q;

endmodule

### src/ptt_back.sv
// Back end: vertex store, sequencer over shared divider and multiplier, result register.
module ptt_back
	import ptt_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  op_t                           q_op,
	input  logic [1:0]                    q_slot,
	input  logic signed [COORD_WIDTH-1:0] q_x,
	input  logic signed [COORD_WIDTH-1:0] q_y,
	input  logic signed [COORD_WIDTH-1:0] q_z,
	input  logic signed [COORD_WIDTH-1:0] q_w,
	ptt_out_if.source                     results
);

	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int DOT_W  = 2 * COORD_WIDTH + 3 - FRAC_BITS;
	localparam int MW     = (DIFF_W > DOT_W) ? DIFF_W : DOT_W;
	localparam int AW     = 2 * MW + 2;
	localparam int XW     = AW + 2;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DIV    = 9'b000000010,
		S_DIFF   = 9'b000000100,
		S_MSTART = 9'b000001000,
		S_MWAIT  = 9'b000010000,
		S_NORM   = 9'b000100000,
		S_SUM    = 9'b001000000,
		S_DECIDE = 9'b010000000,
		S_EMIT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic signed [COORD_WIDTH-1:0] vx_q [NUM_VERTS];
	logic signed [COORD_WIDTH-1:0] vy_q [NUM_VERTS];
	logic signed [COORD_WIDTH-1:0] vz_q [NUM_VERTS];
	logic signed [COORD_WIDTH-1:0] cx_q, cy_q, cz_q, cw_q;
	logic signed [COORD_WIDTH-1:0] p_q [NUM_VERTS];
	logic signed [DIFF_W-1:0]      v0_q [NUM_VERTS];
	logic signed [DIFF_W-1:0]      v1_q [NUM_VERTS];
	logic signed [DIFF_W-1:0]      v2_q [NUM_VERTS];
	logic signed [DOT_W-1:0]       d00_q, d01_q, d02_q, d11_q, d12_q;
	logic signed [AW-1:0]          acc_q, den_q, nu_q, nv_q;
	logic signed [XW-1:0]          dn_q, un_q, vn_q, tot_q;
	logic [1:0]                    cidx_q;
	logic                          div_go_q;
	logic [PIDX_W-1:0]             pidx_q;
	logic                          res_in_q, res_dg_q, res_wz_q;
	logic                          out_valid_q, out_in_q, out_dg_q, out_wz_q;

	logic                          div_start;
	logic signed [COORD_WIDTH-1:0] div_num;
	logic                          div_done;
	logic signed [COORD_WIDTH-1:0] div_quo;
	logic                          mul_start;
	logic signed [MW-1:0]          mul_a, mul_b;
	logic                          mul_done;
	logic signed [2*MW-1:0]        mul_prod;
	logic                          emit;
	prod_step_t                    step;
	logic signed [AW-1:0]          pext, acc_sum, acc_sh;
	logic signed [XW-1:0]          den_x, nu_x, nv_x;

	function automatic logic signed [MW-1:0] pick(input src_t s);
		logic signed [MW-1:0] r;
		unique case (s)
			SRC_V0X: r = MW'(v0_q[0]);
			SRC_V0Y: r = MW'(v0_q[1]);
			SRC_V0Z: r = MW'(v0_q[2]);
			SRC_V1X: r = MW'(v1_q[0]);
			SRC_V1Y: r = MW'(v1_q[1]);
			SRC_V1Z: r = MW'(v1_q[2]);
			SRC_V2X: r = MW'(v2_q[0]);
			SRC_V2Y: r = MW'(v2_q[1]);
			SRC_V2Z: r = MW'(v2_q[2]);
			SRC_D00: r = MW'(d00_q);
			SRC_D01: r = MW'(d01_q);
			SRC_D02: r = MW'(d02_q);
			SRC_D11: r = MW'(d11_q);
			SRC_D12: r = MW'(d12_q);
			default: r = '0;
		endcase
		return r;
	endfunction

	assign q_pop     = (state_q == S_IDLE);
	assign div_start = (state_q == S_DIV) && div_go_q;
	assign mul_start = (state_q == S_MSTART);
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || results.ready);
	assign step      = prod_step(pidx_q);
	assign mul_a     = pick(step.a);
	assign mul_b     = pick(step.b);

	always_comb begin
		unique case (cidx_q)
			2'd0:    div_num = cx_q;
			2'd1:    div_num = cy_q;
			default: div_num = cz_q;
		endcase
	end

	assign pext    = AW'(mul_prod);
	assign acc_sum = step.neg ? (acc_q - pext) : (acc_q + pext);
	assign acc_sh  = acc_sum >>> FRAC_BITS;
	assign den_x   = XW'(den_q);
	assign nu_x    = XW'(nu_q);
	assign nv_x    = XW'(nv_q);

	ptt_div #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.dvs   (cw_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	ptt_mul #(
		.MW(MW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	// Control and vertex store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			div_go_q    <= 1'b0;
			cidx_q      <= '0;
			pidx_q      <= '0;
			for (int i = 0; i < NUM_VERTS; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
				vz_q[i] <= '0;
			end
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						unique case (q_op)
							OP_LOAD: begin
								vx_q[q_slot] <= q_x;
								vy_q[q_slot] <= q_y;
								vz_q[q_slot] <= q_z;
							end
							OP_WZERO: begin
								state_q <= S_EMIT;
							end
							OP_TEST: begin
								state_q  <= S_DIV;
								div_go_q <= 1'b1;
								cidx_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					div_go_q <= 1'b0;
					if (div_done) begin
						if (cidx_q == 2'd2) begin
							state_q <= S_DIFF;
						end else begin
							cidx_q   <= cidx_q + 1'b1;
							div_go_q <= 1'b1;
						end
					end
				end
				S_DIFF: begin
					state_q <= S_MSTART;
					pidx_q  <= '0;
				end
				S_MSTART: begin
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (mul_done) begin
						if (pidx_q == LAST_PROD) begin
							state_q <= S_NORM;
						end else begin
							pidx_q  <= pidx_q + 1'b1;
							state_q <= S_MSTART;
						end
					end
				end
				S_NORM: begin
					state_q <= (den_q == '0) ? S_EMIT : S_SUM;
				end
				S_SUM: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) begin
			cx_q     <= q_x;
			cy_q     <= q_y;
			cz_q     <= q_z;
			cw_q     <= q_w;
			res_in_q <= 1'b0;
			res_dg_q <= 1'b0;
			res_wz_q <= (q_op == OP_WZERO);
		end
		if (state_q == S_DIV && div_done) begin
			p_q[cidx_q] <= div_quo;
		end
		if (state_q == S_DIFF) begin
			v0_q[0] <= DIFF_W'(vx_q[2]) - DIFF_W'(vx_q[0]);
			v0_q[1] <= DIFF_W'(vy_q[2]) - DIFF_W'(vy_q[0]);
			v0_q[2] <= DIFF_W'(vz_q[2]) - DIFF_W'(vz_q[0]);
			v1_q[0] <= DIFF_W'(vx_q[1]) - DIFF_W'(vx_q[0]);
			v1_q[1] <= DIFF_W'(vy_q[1]) - DIFF_W'(vy_q[0]);
			v1_q[2] <= DIFF_W'(vz_q[1]) - DIFF_W'(vz_q[0]);
			v2_q[0] <= DIFF_W'(p_q[0]) - DIFF_W'(vx_q[0]);
			v2_q[1] <= DIFF_W'(p_q[1]) - DIFF_W'(vy_q[0]);
			v2_q[2] <= DIFF_W'(p_q[2]) - DIFF_W'(vz_q[0]);
			acc_q   <= '0;
		end
		if (state_q == S_MWAIT && mul_done) begin
			unique case (step.dst)
				DST_NONE: acc_q <= acc_sum;
				DST_D00: begin
					d00_q <= acc_sh[DOT_W-1:0];
					acc_q <= '0;
				end
				DST_D01: begin
					d01_q <= acc_sh[DOT_W-1:0];
					acc_q <= '0;
				end
				DST_D02: begin
					d02_q <= acc_sh[DOT_W-1:0];
					acc_q <= '0;
				end
				DST_D11: begin
					d11_q <= acc_sh[DOT_W-1:0];
					acc_q <= '0;
				end
				DST_D12: begin
					d12_q <= acc_sh[DOT_W-1:0];
					acc_q <= '0;
				end
				DST_DEN: begin
					den_q <= acc_sum;
					acc_q <= '0;
				end
				DST_NU: begin
					nu_q  <= acc_sum;
					acc_q <= '0;
				end
				DST_NV: begin
					nv_q  <= acc_sum;
					acc_q <= '0;
				end
				default: acc_q <= acc_sum;
			endcase
		end
		if (state_q == S_NORM) begin
			// Flip every sign when den came out negative.
			res_dg_q <= (den_q == '0);
			if (den_q[AW-1]) begin
				dn_q <= -den_x;
				un_q <= -nu_x;
				vn_q <= -nv_x;
			end else begin
				dn_q <= den_x;
				un_q <= nu_x;
				vn_q <= nv_x;
			end
		end
		if (state_q == S_SUM) begin
			tot_q <= un_q + vn_q;
		end
		if (state_q == S_DECIDE) begin
			res_in_q <= !un_q[XW-1] && !vn_q[XW-1] && !((dn_q - un_q) < 0)
				&& !((dn_q - vn_q) < 0) && !((dn_q - tot_q) < 0);
		end
		if (emit) begin
			out_in_q <= res_in_q;
			out_dg_q <= res_dg_q;
			out_wz_q <= res_wz_q;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.is_inside  = out_in_q;
	assign results.degenerate = out_dg_q;
	assign results.w_is_zero  = out_wz_q;

endmodule

### src/point_in_triangle_test.sv
// Top level of the fixed-point barycentric point-in-triangle test.
//
// Channels: items (valid/ready) carries one transaction per load or test; results
// (valid/ready) carries one transaction per test and none per load.
// A load (kind 0) writes vertex P1, P2 or P3 by vertex_slot; slot 3 is ignored.
// A test (kind 1) divides x, y, z by w on the bit-serial divider, forms the edge
// and point vectors, then runs 21 products on the shared digit-serial multiplier
// (its width MW the wider of the difference and dot widths) to build den, nu and
// nv, and decides inside/outside.
// A zero w skips the arithmetic and still returns a result, with w_is_zero set.
// Tests are processed one at a time; throughput is set by the divider and the
// multiplier. A two-entry queue lets the front keep accepting while the back works,
// and a result register holds the finished result while the next test starts.
// If results.ready stays low, the back end finishes its current test, then waits;
// the queue fills and items.ready drops.
// Reset clears all three vertices to zero and empties the queue and result register.
module point_in_triangle_test
	import ptt_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ptt_in_if.sink    items,
	ptt_out_if.source results
);

	// Front-to-back queue head.
	logic                          q_valid;
	logic                          q_pop;
	op_t                           q_op;
	logic [1:0]                    q_slot;
	logic signed [COORD_WIDTH-1:0] q_x;
	logic signed [COORD_WIDTH-1:0] q_y;
	logic signed [COORD_WIDTH-1:0] q_z;
	logic signed [COORD_WIDTH-1:0] q_w;

	ptt_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.q_valid(q_valid),
		.q_pop  (q_pop),
		.q_op   (q_op),
		.q_slot (q_slot),
		.q_x    (q_x),
		.q_y    (q_y),
		.q_z    (q_z),
		.q_w    (q_w)
	);

	// Back end owns the vertex store so loads and tests stay in order.
	ptt_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_pop  (q_pop),
		.q_op   (q_op),
		.q_slot (q_slot),
		.q_x    (q_x),
		.q_y    (q_y),
		.q_z    (q_z),
		.q_w    (q_w),
		.results(results)
	);

endmodule
